// ===== rtl/cic_pkg.sv =====
// Shared types, constants and the byte-wise CRC-32 update for the image checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cic_pkg;

	localparam int unsigned LenW       = 20;
	localparam int unsigned CrcW       = 32;
	localparam int unsigned ByteW      = 8;
	localparam int unsigned ResultW    = 1 + 2 * CrcW;
	localparam int unsigned ResultPadW = ((ResultW + 7) / 8) * 8;

	localparam logic [CrcW-1:0] CrcPoly     = 32'hEDB8_8320;
	localparam logic [CrcW-1:0] CrcInit     = 32'hFFFF_FFFF;
	localparam logic [LenW-1:0] LenReset    = 20'h1_E000;
	localparam logic [LenW-1:0] MinLength   = 20'd5;
	localparam logic [LenW-1:0] TrailerBytes = 20'd4;

	typedef struct packed {
		logic [CrcW-1:0] stored_crc;
		logic [CrcW-1:0] computed_crc;
		logic            crc_ok;
	} cic_result_t;

	// one byte through the reflected CRC-32, LSB first
	function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc_in,
			input logic [ByteW-1:0] b);
		logic [CrcW-1:0] r;
		r = crc_in ^ {{(CrcW-ByteW){1'b0}}, b};
		for (int k = 0; k < ByteW; k++) begin
			if (r[0]) begin
				r = (r >> 1) ^ CrcPoly;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/cic_engine.sv =====
// Image state (CRC register, byte position, trailer word) and length register.
// Depends on cic_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cic_engine (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [cic_pkg::LenW-1:0]  cfg_data,
	input  wire logic                      advance,
	input  wire logic [cic_pkg::ByteW-1:0] data_byte,
	output logic                           last,
	output cic_pkg::cic_result_t           res
);

	logic [cic_pkg::LenW-1:0] image_length_q;
	logic [cic_pkg::CrcW-1:0] crc_q;
	logic [cic_pkg::LenW-1:0] pos_q;
	logic [cic_pkg::CrcW-1:0] trailer_q;

	logic [cic_pkg::LenW-1:0] len_eff;
	logic [cic_pkg::LenW-1:0] crc_end;
	logic [cic_pkg::LenW:0]   pos_next;
	logic                     in_body;
	logic [cic_pkg::CrcW-1:0] crc_upd;
	logic [cic_pkg::CrcW-1:0] trailer_upd;
	logic [cic_pkg::CrcW-1:0] computed;

	always_comb begin
		len_eff     = (image_length_q < cic_pkg::MinLength) ? cic_pkg::MinLength
			: image_length_q;
		crc_end     = len_eff - cic_pkg::TrailerBytes;
		in_body     = pos_q < crc_end;
		pos_next    = {1'b0, pos_q} + {{cic_pkg::LenW{1'b0}}, 1'b1};
		last        = pos_next >= {1'b0, len_eff};
		crc_upd     = in_body ? cic_pkg::crc_byte(crc_q, data_byte) : crc_q;
		trailer_upd = in_body ? trailer_q : {data_byte, trailer_q[cic_pkg::CrcW-1:8]};
		computed    = ~crc_upd;
		res.crc_ok       = computed == trailer_upd;
		res.computed_crc = computed;
		res.stored_crc   = trailer_upd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_length_q <= cic_pkg::LenReset;
		end else if (cfg_we) begin
			image_length_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= cic_pkg::CrcInit;
			pos_q     <= '0;
			trailer_q <= '0;
		end else if (advance) begin
			if (last) begin
				crc_q     <= cic_pkg::CrcInit;
				pos_q     <= '0;
				trailer_q <= '0;
			end else begin
				crc_q     <= crc_upd;
				pos_q     <= pos_next[cic_pkg::LenW-1:0];
				trailer_q <= trailer_upd;
			end
		end
	end

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last |=> pos_q == '0 && crc_q == cic_pkg::CrcInit && trailer_q == '0)
		else $error("image state not restarted after final byte");

	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !last |=> pos_q == $past(pos_next[cic_pkg::LenW-1:0]))
		else $error("byte position did not step");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(pos_q) && $stable(crc_q) && $stable(trailer_q))
		else $error("image state changed without a byte");

endmodule
`default_nettype wire

// ===== rtl/crc32_image_check.sv =====
// Top level of the streaming CRC-32 image checker: input register, engine, result register.
// Depends on cic_pkg and cic_engine.
`timescale 1ns / 1ps
`default_nettype none
// Streams image bytes in address order on s_axis, one per transfer, and takes up to one
// byte per cycle. Each byte waits in the input register, where a single byte-wide CRC-32
// step updates the running state. Only the final byte of an image can be held there, and
// only while the result register still holds an earlier result that m_axis has not taken.
// The final byte loads the result register as it leaves the input register. One result
// per image, on the final byte; the block then restarts for the next image. image_length
// (cfg_data) counts all bytes including the four little-endian trailer bytes; values
// below 5 act as 5. Write it only while no image is in flight.
module crc32_image_check (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [cic_pkg::LenW-1:0]           cfg_data,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [cic_pkg::ByteW-1:0]          s_axis_tdata,   // data_byte
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	output logic [cic_pkg::ResultPadW-1:0]          m_axis_tdata    // crc_ok, computed_crc,
	                                                                // stored_crc, zero pad
);

	logic                       valid_s1;
	logic [cic_pkg::ByteW-1:0]  byte_s1;
	logic                       last;
	logic                       advance;
	cic_pkg::cic_result_t       res;
	cic_pkg::cic_result_t       res_q;
	logic                       res_valid_q;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!last || !res_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	cic_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.advance   (advance),
		.data_byte (byte_s1),
		.last      (last),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && last) begin
			res_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = {{(cic_pkg::ResultPadW - cic_pkg::ResultW){1'b0}}, res_q};

endmodule
`default_nettype wire

// ===== tb/cic_tb_pkg.sv =====
// Testbench helpers for the CRC-32 image checker: bit-serial reflected CRC-32 byte update.
// Used by the result checker and by the frame generator in tb_top. No dependencies.
`timescale 1ns / 1ps
package cic_tb_pkg;

	localparam logic [31:0] ReflPoly = 32'hEDB8_8320;

	// one byte, LSB first, one bit per iteration
	function automatic logic [31:0] crc32_shift_byte(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] r;
		logic        fb;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r = {1'b0, r[31:1]} ^ (fb ? ReflPoly : 32'h0);
		end
		return r;
	endfunction

endpackage

// ===== tb/cic_result_checker.sv =====
// Passive checker for crc32_image_check: tracks length writes and byte transfers, predicts
// each image verdict and compares it with the result transfers. Depends on cic_pkg, cic_tb_pkg.
`timescale 1ns / 1ps
module cic_result_checker
	import cic_pkg::*;
	import cic_tb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [LenW-1:0]       cfg_data,
	input  wire logic                  s_axis_tvalid,
	input  wire logic                  s_axis_tready,
	input  wire logic [ByteW-1:0]      s_axis_tdata,   // data_byte
	input  wire logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	input  wire logic [ResultPadW-1:0] m_axis_tdata,   // crc_ok, computed_crc, stored_crc, pad
	output int unsigned                mismatches,
	output int unsigned                outstanding
);

	logic [LenW-1:0] image_len;
	logic [CrcW-1:0] crc_acc;
	logic [LenW-1:0] byte_pos;
	logic [CrcW-1:0] trailer;
	cic_result_t     awaited_verdicts[$];

	always @(posedge clk or negedge arst_n) begin : watch
		cic_result_t seen;
		cic_result_t want;
		int unsigned span;
		int unsigned errs;
		if (!arst_n) begin
			image_len = LenReset;
			crc_acc   = CrcInit;
			byte_pos  = '0;
			trailer   = '0;
			awaited_verdicts.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			errs = 0;
			if (m_axis_tvalid && m_axis_tready) begin
				seen = m_axis_tdata[ResultW-1:0];
				if (awaited_verdicts.size() == 0) begin
					$error("result transfer with no verdict awaited: %h", m_axis_tdata);
					errs++;
				end else begin
					want = awaited_verdicts.pop_front();
					if (seen.crc_ok !== want.crc_ok) begin
						$error("crc_ok: expected %0d, actual %0d", want.crc_ok, seen.crc_ok);
						errs++;
					end
					if (seen.computed_crc !== want.computed_crc) begin
						$error("computed_crc: expected %h, actual %h",
							want.computed_crc, seen.computed_crc);
						errs++;
					end
					if (seen.stored_crc !== want.stored_crc) begin
						$error("stored_crc: expected %h, actual %h",
							want.stored_crc, seen.stored_crc);
						errs++;
					end
					if (m_axis_tdata[ResultPadW-1:ResultW] !== '0) begin
						$error("pad: expected 0, actual %h", m_axis_tdata[ResultPadW-1:ResultW]);
						errs++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				image_len = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				span = (image_len < MinLength) ? MinLength : image_len;
				if (byte_pos < span - TrailerBytes) begin
					crc_acc = crc32_shift_byte(crc_acc, s_axis_tdata);
				end else begin
					trailer = {s_axis_tdata, trailer[CrcW-1:8]};
				end
				if (byte_pos + 1 >= span) begin
					want.computed_crc = ~crc_acc;
					want.stored_crc   = trailer;
					want.crc_ok       = (~crc_acc == trailer);
					awaited_verdicts.push_back(want);
					crc_acc  = CrcInit;
					byte_pos = '0;
					trailer  = '0;
				end else begin
					byte_pos = byte_pos + 1'b1;
				end
			end
			mismatches  <= mismatches + errs;
			outstanding <= awaited_verdicts.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Top of the crc32_image_check testbench: clock, reset, image frame generator and verdict.
// Depends on cic_pkg, cic_tb_pkg, cic_result_checker and the RTL top crc32_image_check.
`timescale 1ns / 1ps
module tb_top;
	import cic_pkg::*;
	import cic_tb_pkg::*;

	typedef enum logic [2:0] {
		TRAILER_GOOD,
		TRAILER_BITFLIP,
		TRAILER_NOISE,
		TRAILER_ZEROS,
		TRAILER_ONES
	} trailer_kind_t;

	localparam int unsigned HoldCycles = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [LenW-1:0]       cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [ByteW-1:0]      s_axis_tdata = '0;   // data_byte
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [ResultPadW-1:0] m_axis_tdata;        // crc_ok, computed_crc, stored_crc, pad

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned bytes_sent = 0;
	int unsigned cur_span = 5;
	bit          long_hold = 1'b0;
	logic [7:0]  frame_body[$];

	crc32_image_check u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	cic_result_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("[crc32_image_check] ERROR");
		$finish;
	end

	// result side: random back-pressure, plus one long hold-off on request
	initial begin : receiver
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				long_hold = 1'b0;
			end
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic write_length(input logic [LenW-1:0] len);
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_span = (len < MinLength) ? MinLength : len;
		@(posedge clk);
	endtask

	// drain every verdict, then let the pipeline settle before touching the length
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// body from frame_body (random where empty), trailer per kind
	task automatic send_frame(input trailer_kind_t kind);
		logic [31:0] crc;
		logic [31:0] word;
		logic [7:0]  b;
		crc = CrcInit;
		for (int i = 0; i < cur_span - 4; i++) begin
			b = (i < frame_body.size()) ? frame_body[i] : 8'($urandom);
			crc = crc32_shift_byte(crc, b);
			send_byte(b);
		end
		frame_body.delete();
		word = ~crc;
		case (kind)
			TRAILER_BITFLIP: word[$urandom_range(31)] ^= 1'b1;
			TRAILER_NOISE:   word = $urandom;
			TRAILER_ZEROS:   word = '0;
			TRAILER_ONES:    word = '1;
			default:         ;
		endcase
		for (int i = 0; i < 4; i++) send_byte(word[8*i +: 8]);
	endtask

	function automatic logic [LenW-1:0] pick_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 5) return LenW'($urandom_range(4));
		if (r < 75) return LenW'($urandom_range(12, 5));
		if (r < 95) return LenW'($urandom_range(64, 13));
		return LenW'($urandom_range(300, 65));
	endfunction

	function automatic trailer_kind_t pick_kind();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 75) return TRAILER_GOOD;
		if (r < 85) return TRAILER_BITFLIP;
		if (r < 94) return TRAILER_NOISE;
		if (r < 97) return TRAILER_ZEROS;
		return TRAILER_ONES;
	endfunction

	initial begin : stimulus
		int unsigned target;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 21;
		rx_idle_pct = 83;

		// zero length acts as the minimum; single zero byte with a matching trailer
		write_length('0);
		frame_body.push_back(8'h00);
		send_frame(TRAILER_GOOD);
		settle();
		// one below the minimum; all-ones body and trailer
		write_length(LenW'(4));
		frame_body.push_back(8'hFF);
		send_frame(TRAILER_ONES);
		settle();
		// largest length written, then replaced before any byte goes in
		write_length('1);
		write_length(MinLength);
		frame_body.push_back(8'hFF);
		send_frame(TRAILER_ZEROS);
		settle();
		write_length(LenW'(7));
		frame_body.push_back(8'h55);
		frame_body.push_back(8'hAA);
		frame_body.push_back(8'h80);
		send_frame(TRAILER_BITFLIP);
		settle();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin tx_idle_pct = 21; rx_idle_pct = 83; end
				1: begin tx_idle_pct = 83; rx_idle_pct = 21; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			target = bytes_sent + 450;
			settle();
			if (phase == 2) begin
				// minimum-size images back to back while the result side is held off
				write_length(MinLength);
				long_hold = 1'b1;
				for (int n = 0; n < 40; n++) send_frame(pick_kind());
				settle();
			end
			write_length(pick_length());
			while (bytes_sent < target) begin
				if ($urandom_range(99) < 35) begin
					settle();
					write_length(pick_length());
				end
				send_frame(pick_kind());
			end
		end

		s_axis_tvalid <= 1'b0;
		for (int n = 0; n < 20000 && outstanding != 0; n++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (outstanding != 0) $error("%0d image verdicts never arrived", outstanding);
		if (mismatches == 0 && outstanding == 0) begin
			$display("[crc32_image_check] OK");
		end else begin
			$display("[crc32_image_check] ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/cic_pkg.sv
rtl/cic_engine.sv
rtl/crc32_image_check.sv
tb/cic_tb_pkg.sv
tb/cic_result_checker.sv
tb/tb_top.sv
